FILE: rtl/core/pksd_pkg.sv
package pksd_pkg;

    localparam int CNT_W = 6;
    localparam int KEY_W = 4;
    localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;
    localparam logic [CNT_W-1:0] DEPTH_RST = 6'd32;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_TAKE   = 2'd1,
        REQ_FINISH = 2'd2,
        REQ_DRAIN  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_FINISH,
        ST_TAKE_REQ,
        ST_TAKE_CHK,
        ST_TAKE_POP,
        ST_DRAIN_KEY,
        ST_DRAIN_POP,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } rf_ctl_t;

    typedef struct packed {
        logic set_used;
        logic clr_used;
        logic link_we;
        logic rd_en;
    } slot_ctl_t;

endpackage

FILE: rtl/core/pksd_ready_fifo.sv
module pksd_ready_fifo
    import pksd_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int KW = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  rf_ctl_t       ctl,
    input  logic [KW-1:0] push_key,
    output logic [KW-1:0] rd_key,
    output logic          nonempty
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [KW-1:0] mem [DEPTH];
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] wr_ptr_reg;
    logic [NW-1:0] count_reg;
    logic [KW-1:0] rd_key_reg;
    logic          full;
    logic          do_push;

    assign full     = (count_reg == NW'(DEPTH));
    assign do_push  = ctl.push && !full;
    assign nonempty = (count_reg != '0);
    assign rd_key   = rd_key_reg;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else if (ctl.flush)
        begin
            rd_ptr_reg <= wr_ptr_reg;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (ctl.pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !ctl.pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (ctl.pop && !do_push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_key;
        end
        if (ctl.pop)
        begin
            rd_key_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

FILE: rtl/core/pksd_slot_mem.sv
module pksd_slot_mem
    import pksd_pkg::*;
#(
    parameter int TC = 32,
    parameter int HB = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  slot_ctl_t              ctl,
    input  logic [$clog2(TC)-1:0]  set_addr,
    input  logic [HB-1:0]          set_handle,
    input  logic [$clog2(TC)-1:0]  clr_addr,
    input  logic [$clog2(TC)-1:0]  link_addr,
    input  logic [$clog2(TC)-1:0]  link_data,
    input  logic [$clog2(TC)-1:0]  rd_addr,
    output logic [HB-1:0]          rd_handle,
    output logic [$clog2(TC)-1:0]  rd_link,
    output logic                   free_valid,
    output logic [$clog2(TC)-1:0]  free_idx,
    output logic [TC-1:0]          used_vec
);

    localparam int SW = $clog2(TC);

    logic [HB-1:0] handle_mem [TC];
    logic [SW-1:0] link_mem [TC];
    logic [TC-1:0] used_reg;
    logic [HB-1:0] rd_handle_reg;
    logic [SW-1:0] rd_link_reg;

    assign used_vec  = used_reg;
    assign rd_handle = rd_handle_reg;
    assign rd_link   = rd_link_reg;

    always_comb
    begin
        free_valid = 1'b0;
        free_idx   = '0;
        for (int i = TC - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_valid = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            if (ctl.set_used)
            begin
                used_reg[set_addr] <= 1'b1;
            end
            if (ctl.clr_used)
            begin
                used_reg[clr_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.set_used)
        begin
            handle_mem[set_addr] <= set_handle;
        end
        if (ctl.link_we)
        begin
            link_mem[link_addr] <= link_data;
        end
        if (ctl.rd_en)
        begin
            rd_handle_reg <= handle_mem[rd_addr];
            rd_link_reg   <= link_mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/per_key_serial_dispatcher_top.sv
// Channel  Handshake            Beat contents
// in       in_valid / in_stall  req_type, key_id, request_handle
// out      out_valid/ out_stall accepted, has_request, out_handle, out_key,
//                               queued_total, ready_pending, last
// cfg      cfg_we               cfg_wdata -> max_depth
// Push and finish each pass through their own state; take pops and checks ready
// entries until one is usable, then reads and pops its head handle. Drain walks
// the keys, paced by the one slot memory read port, reading each handle in turn.
// Reset clears all control state at once; no clearing pass.
// A request is taken only when the output register is free; each result beat
// waits in its state while the output register holds a stalled beat.
module per_key_serial_dispatcher_top
    import pksd_pkg::*;
#(
    parameter int NUM_KEYS = 16,
    parameter int TOTAL_CAPACITY = 32,
    parameter int HANDLE_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CNT_W-1:0]       cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             req_type,
    input  logic [KEY_W-1:0]       key_id,
    input  logic [HANDLE_BITS-1:0] request_handle,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   accepted,
    output logic                   has_request,
    output logic [HANDLE_BITS-1:0] out_handle,
    output logic [KEY_W-1:0]       out_key,
    output logic [CNT_W-1:0]       queued_total,
    output logic                   ready_pending,
    output logic                   last
);

    localparam int KW  = $clog2(NUM_KEYS);
    localparam int KXW = (KW > KEY_W) ? KW : KEY_W;
    localparam int SW  = $clog2(TOTAL_CAPACITY);
    localparam int UW  = $clog2(TOTAL_CAPACITY + 1);
    localparam int CW  = (UW > CNT_W) ? UW : CNT_W;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]       max_depth_reg;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [UW-1:0]          used_cnt_reg, used_cnt_next;
    logic [KW-1:0]          cur_key_reg, cur_key_next;
    logic [1:0]             in_type_reg;
    logic [KEY_W-1:0]       in_key_reg;
    logic [HANDLE_BITS-1:0] in_handle_reg;

    logic                   present_reg [NUM_KEYS];
    logic                   busy_reg [NUM_KEYS];
    logic [UW-1:0]          wait_reg [NUM_KEYS];
    logic [SW-1:0]          head_reg [NUM_KEYS];
    logic [SW-1:0]          tail_reg [NUM_KEYS];

    logic                   out_valid_reg;
    logic                   out_acc_reg, out_has_reg, out_last_reg;
    logic [HANDLE_BITS-1:0] out_handle_reg;
    logic [KW-1:0]          out_key_reg;

    logic                   out_free, in_acc;
    logic                   out_load, o_acc, o_has, o_last;
    logic [KW-1:0]          ki;
    logic                   key_en;
    logic                   p_n, b_n;
    logic [UW-1:0]          w_n;
    logic [SW-1:0]          h_n, t_n;
    logic                   key_ok;
    logic [KXW-1:0]         in_key_x;

    rf_ctl_t                fctl;
    logic [KW-1:0]          f_push_key;
    logic [KW-1:0]          f_rd_key;
    logic                   f_nonempty;

    slot_ctl_t              sctl;
    logic [SW-1:0]          s_rd_addr, s_link_addr, s_clr_addr;
    logic [HANDLE_BITS-1:0] s_rd_handle;
    logic [SW-1:0]          s_rd_link;
    logic                   s_free_valid;
    logic [SW-1:0]          s_free_idx;
    logic [TOTAL_CAPACITY-1:0] s_used_vec;

    pksd_ready_fifo #(
        .DEPTH (TOTAL_CAPACITY),
        .KW    (KW)
    ) u_ready (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (fctl),
        .push_key (f_push_key),
        .rd_key   (f_rd_key),
        .nonempty (f_nonempty)
    );

    pksd_slot_mem #(
        .TC (TOTAL_CAPACITY),
        .HB (HANDLE_BITS)
    ) u_slots (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sctl),
        .set_addr   (s_free_idx),
        .set_handle (in_handle_reg),
        .clr_addr   (s_clr_addr),
        .link_addr  (s_link_addr),
        .link_data  (s_free_idx),
        .rd_addr    (s_rd_addr),
        .rd_handle  (s_rd_handle),
        .rd_link    (s_rd_link),
        .free_valid (s_free_valid),
        .free_idx   (s_free_idx),
        .used_vec   (s_used_vec)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign in_acc   = in_valid && !in_stall;
    assign in_key_x = KXW'(in_key_reg);
    assign key_ok   = ({1'b0, in_key_x} < (KXW + 1)'(NUM_KEYS));

    always_comb
    begin
        state_next    = state_reg;
        total_next    = total_reg;
        used_cnt_next = used_cnt_reg;
        cur_key_next  = cur_key_reg;
        out_load      = 1'b0;
        o_acc         = 1'b0;
        o_has         = 1'b0;
        o_last        = 1'b1;
        fctl          = '0;
        f_push_key    = in_key_x[KW-1:0];
        sctl          = '0;
        s_rd_addr     = '0;
        s_link_addr   = '0;
        s_clr_addr    = '0;
        key_en        = 1'b0;
        ki            = cur_key_reg;
        p_n           = 1'b0;
        b_n           = 1'b0;
        w_n           = '0;
        h_n           = '0;
        t_n           = '0;

        unique case (state_reg)
            ST_PUSH, ST_FINISH:
            begin
                ki = in_key_x[KW-1:0];
            end
            ST_TAKE_CHK:
            begin
                ki = f_rd_key;
            end
            default:
            begin
                ki = cur_key_reg;
            end
        endcase

        p_n = present_reg[ki];
        b_n = busy_reg[ki];
        w_n = wait_reg[ki];
        h_n = head_reg[ki];
        t_n = tail_reg[ki];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (req_t'(req_type))
                        REQ_PUSH:   state_next = ST_PUSH;
                        REQ_TAKE:   state_next = ST_TAKE_REQ;
                        REQ_FINISH: state_next = ST_FINISH;
                        REQ_DRAIN:
                        begin
                            fctl.flush   = 1'b1;
                            cur_key_next = '0;
                            if (CW'(total_reg) > CW'(used_cnt_reg))
                            begin
                                total_next = CNT_W'(CW'(total_reg) - CW'(used_cnt_reg));
                            end
                            else
                            begin
                                total_next = '0;
                            end
                            state_next = (used_cnt_reg == '0) ? ST_EMPTY : ST_DRAIN_KEY;
                        end
                    endcase
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (key_ok && (total_reg < max_depth_reg) && s_free_valid)
                    begin
                        o_acc         = 1'b1;
                        sctl.set_used = 1'b1;
                        key_en        = 1'b1;
                        if (wait_reg[ki] == '0)
                        begin
                            h_n = s_free_idx;
                        end
                        else
                        begin
                            sctl.link_we = 1'b1;
                            s_link_addr  = tail_reg[ki];
                        end
                        t_n           = s_free_idx;
                        w_n           = wait_reg[ki] + UW'(1);
                        p_n           = 1'b1;
                        used_cnt_next = used_cnt_reg + UW'(1);
                        if (total_reg < CNT_MAX)
                        begin
                            total_next = total_reg + CNT_W'(1);
                        end
                        fctl.push = !busy_reg[ki] && (wait_reg[ki] == '0);
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (key_ok && present_reg[ki])
                    begin
                        key_en = 1'b1;
                        b_n    = 1'b0;
                        if (total_reg != '0)
                        begin
                            total_next = total_reg - CNT_W'(1);
                        end
                        if (wait_reg[ki] == '0)
                        begin
                            p_n = 1'b0;
                        end
                        else
                        begin
                            fctl.push = 1'b1;
                        end
                    end
                end
            end
            ST_TAKE_REQ:
            begin
                if (f_nonempty)
                begin
                    fctl.pop   = 1'b1;
                    state_next = ST_TAKE_CHK;
                end
                else
                begin
                    state_next = ST_EMPTY;
                end
            end
            ST_TAKE_CHK:
            begin
                if (!present_reg[ki] || busy_reg[ki] || (wait_reg[ki] == '0))
                begin
                    state_next = ST_TAKE_REQ;
                end
                else
                begin
                    key_en       = 1'b1;
                    b_n          = 1'b1;
                    sctl.rd_en   = 1'b1;
                    s_rd_addr    = head_reg[ki];
                    cur_key_next = f_rd_key;
                    state_next   = ST_TAKE_POP;
                end
            end
            ST_TAKE_POP, ST_DRAIN_POP:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    o_has         = 1'b1;
                    key_en        = 1'b1;
                    h_n           = s_rd_link;
                    w_n           = wait_reg[ki] - UW'(1);
                    sctl.clr_used = 1'b1;
                    s_clr_addr    = head_reg[ki];
                    used_cnt_next = used_cnt_reg - UW'(1);
                    if (state_reg == ST_TAKE_POP)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        o_last = (used_cnt_reg == UW'(1));
                        if (o_last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_DRAIN_KEY;
                            if (wait_reg[ki] == UW'(1))
                            begin
                                cur_key_next = cur_key_reg + KW'(1);
                            end
                        end
                    end
                end
            end
            ST_DRAIN_KEY:
            begin
                if (wait_reg[ki] != '0)
                begin
                    sctl.rd_en = 1'b1;
                    s_rd_addr  = head_reg[ki];
                    state_next = ST_DRAIN_POP;
                end
                else
                begin
                    cur_key_next = cur_key_reg + KW'(1);
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_depth_reg <= DEPTH_RST;
            total_reg     <= '0;
            used_cnt_reg  <= '0;
            cur_key_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                present_reg[i] <= 1'b0;
                busy_reg[i]    <= 1'b0;
                wait_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            used_cnt_reg <= used_cnt_next;
            cur_key_reg  <= cur_key_next;
            if (cfg_we)
            begin
                max_depth_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (key_en)
            begin
                present_reg[ki] <= p_n;
                busy_reg[ki]    <= b_n;
                wait_reg[ki]    <= w_n;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_type_reg   <= req_type;
            in_key_reg    <= key_id;
            in_handle_reg <= request_handle;
        end
        if (key_en)
        begin
            head_reg[ki] <= h_n;
            tail_reg[ki] <= t_n;
        end
        if (out_load)
        begin
            out_acc_reg    <= o_acc;
            out_has_reg    <= o_has;
            out_last_reg   <= o_last;
            out_handle_reg <= o_has ? s_rd_handle : '0;
            out_key_reg    <= o_has ? cur_key_reg : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = out_acc_reg;
    assign has_request   = out_has_reg;
    assign out_handle    = out_handle_reg;
    assign out_key       = KEY_W'(KXW'(out_key_reg));
    assign last          = out_last_reg;
    assign queued_total  = total_reg;
    assign ready_pending = f_nonempty;

    a_used_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(s_used_vec) == int'(used_cnt_reg)))
        else $error("used slot count out of step with slot flags");

    a_accept_empties_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !out_valid_reg)
        else $error("request taken while a result beat was pending");

    a_acc_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_acc_reg) |-> !out_has_reg)
        else $error("push result carries a handle");

    a_push_type: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> (in_type_reg == REQ_PUSH))
        else $error("push sequence entered for another request");

endmodule
